// ===== src/pnf_pkg.sv =====
package pnf_pkg;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    localparam int COORD_W = 8;
    localparam int SIZE_W  = 9;
    localparam int ELEV_W  = 32;
    localparam int COUNT_W = 4;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 9'd256;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [0:0] {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                      operation;
        logic [COORD_W-1:0]        cell_row;
        logic [COORD_W-1:0]        cell_col;
        logic signed [ELEV_W-1:0]  cell_elevation;
        logic                      cell_flow_valid;
    } in_word_t;

    typedef struct packed {
        logic                found;
        logic [COORD_W-1:0]  match_row;
        logic [COORD_W-1:0]  match_col;
        logic                last_result;
        logic [COUNT_W-1:0]  total_count;
    } out_word_t;

    typedef struct packed {
        logic                      flow_valid;
        logic signed [ELEV_W-1:0]  elevation;
    } grid_cell_t;

endpackage

// ===== src/pnf_grid_mem.sv =====
module pnf_grid_mem #(
    parameter int DEPTH = pnf_pkg::DEF_MAX_ROWS * pnf_pkg::DEF_MAX_COLS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                mem_en,
    input  logic                mem_we,
    input  logic [AW-1:0]       mem_addr,
    input  pnf_pkg::grid_cell_t mem_wdata,
    output pnf_pkg::grid_cell_t mem_rdata
);

    pnf_pkg::grid_cell_t mem_array [DEPTH];
    pnf_pkg::grid_cell_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_en) begin
            if (mem_we) begin
                mem_array[mem_addr] <= mem_wdata;
            end else begin
                rdata_reg <= mem_array[mem_addr];
            end
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

// ===== src/pnf_result_stage.sv =====
module pnf_result_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pnf_pkg::out_word_t push_word,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output pnf_pkg::out_word_t m_word
);

    logic               valid_reg;
    pnf_pkg::out_word_t word_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            word_reg <= push_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

endmodule

// ===== src/plateau_neighbor_finder_core.sv =====
// Channel  | Ports                          | Word
// ---------+--------------------------------+-------------------------------
// input    | s_valid, s_ready, s_word       | pnf_pkg::in_word_t
// result   | m_valid, m_ready, m_word       | pnf_pkg::out_word_t
// config   | cfg_we, cfg_index, cfg_wdata   | grid_rows, grid_cols (9 bits)
//
// A write word is taken in the idle state. A query with a full window issues the centre
// read on its acceptance, takes the centre value, reads nine window cells one at a time on
// the single memory port, then finishes the last compare, closes the scan and hands over
// the final word; only then is the next word accepted.
// Reset is synchronous and active low; the grid memory is not cleared.
// A stalled result channel holds the scan when a new match finds the result register
// still full, and holds the final word until the register frees up.
module plateau_neighbor_finder_core #(
    parameter int MAX_ROWS = pnf_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = pnf_pkg::DEF_MAX_COLS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pnf_pkg::in_word_t           s_word,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pnf_pkg::out_word_t          m_word,
    input  logic                        cfg_we,
    input  pnf_pkg::reg_index_t         cfg_index,
    input  logic [pnf_pkg::SIZE_W-1:0]  cfg_wdata
);

    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int AW       = $clog2(DEPTH);
    localparam int LIM_ROWS = (MAX_ROWS < 256) ? MAX_ROWS : 256;
    localparam int LIM_COLS = (MAX_COLS < 256) ? MAX_COLS : 256;
    localparam int CW       = pnf_pkg::COORD_W;
    localparam int SW       = pnf_pkg::SIZE_W;
    localparam int NW       = pnf_pkg::COUNT_W;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                                 input logic [CW-1:0] c);
        cell_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    pnf_pkg::state_t state_reg, state_next;

    logic [SW-1:0] rows_reg, cols_reg;
    logic [CW-1:0] whi_reg, zlo_reg, zhi_reg;
    logic [CW-1:0] rd_row_reg, rd_col_reg;
    logic          rd_left_reg;
    logic          cmp_valid_reg;
    logic [CW-1:0] cmp_row_reg, cmp_col_reg;
    logic signed [pnf_pkg::ELEV_W-1:0] centre_reg;
    logic          pend_valid_reg;
    logic [CW-1:0] pend_row_reg, pend_col_reg;
    logic [NW-1:0] cnt_reg;

    logic [SW-1:0] rows_eff, cols_eff;
    logic          s_accept, is_query, in_grid, in_store;
    logic [CW-1:0] wlo_new, whi_new, zlo_new, zhi_new;
    logic          out_free, push;
    pnf_pkg::out_word_t push_word;
    logic          cmp_match, cmp_adv, rd_issue, scan_done;
    logic          mem_en, mem_we;
    logic [AW-1:0] mem_addr;
    pnf_pkg::grid_cell_t mem_wdata, mem_rdata;

    always_comb begin
        rows_eff = rows_reg;
        if (rows_reg == '0) begin
            rows_eff = SW'(1);
        end else if (rows_reg > SW'(LIM_ROWS)) begin
            rows_eff = SW'(LIM_ROWS);
        end
        cols_eff = cols_reg;
        if (cols_reg == '0) begin
            cols_eff = SW'(1);
        end else if (cols_reg > SW'(LIM_COLS)) begin
            cols_eff = SW'(LIM_COLS);
        end
    end

    assign s_accept = s_valid && s_ready;
    assign is_query = (s_word.operation == pnf_pkg::OP_QUERY);
    assign in_grid  = ({1'b0, s_word.cell_row} < rows_eff) &&
                      ({1'b0, s_word.cell_col} < cols_eff);
    assign in_store = (32'(s_word.cell_row) < MAX_ROWS) &&
                      (32'(s_word.cell_col) < MAX_COLS);

    always_comb begin
        wlo_new = (s_word.cell_row == '0) ? '0 : s_word.cell_row - CW'(1);
        zlo_new = (s_word.cell_col == '0) ? '0 : s_word.cell_col - CW'(1);
        whi_new = (({1'b0, s_word.cell_row} + SW'(1)) < rows_eff) ?
                  s_word.cell_row + CW'(1) : CW'(rows_eff - SW'(1));
        zhi_new = (({1'b0, s_word.cell_col} + SW'(1)) < cols_eff) ?
                  s_word.cell_col + CW'(1) : CW'(cols_eff - SW'(1));
    end

    assign cmp_match = cmp_valid_reg && mem_rdata.flow_valid &&
                       (mem_rdata.elevation == centre_reg);
    assign cmp_adv   = cmp_valid_reg && !(cmp_match && pend_valid_reg && !out_free);
    assign scan_done = (state_reg == pnf_pkg::ST_SCAN) && !rd_left_reg && !cmp_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pnf_pkg::ST_IDLE: begin
                if (s_accept && is_query) begin
                    state_next = in_grid ? pnf_pkg::ST_CENTRE : pnf_pkg::ST_FINISH;
                end
            end
            pnf_pkg::ST_CENTRE: begin
                state_next = pnf_pkg::ST_SCAN;
            end
            pnf_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = pnf_pkg::ST_FINISH;
                end
            end
            pnf_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = pnf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pnf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        rd_issue  = 1'b0;
        push      = 1'b0;
        push_word = '0;
        unique case (state_reg)
            pnf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            pnf_pkg::ST_SCAN: begin
                rd_issue = rd_left_reg && (!cmp_valid_reg || cmp_adv);
                if (cmp_adv && cmp_match && pend_valid_reg) begin
                    push                = 1'b1;
                    push_word.found     = 1'b1;
                    push_word.match_row = pend_row_reg;
                    push_word.match_col = pend_col_reg;
                end
            end
            pnf_pkg::ST_FINISH: begin
                push                  = out_free;
                push_word.found       = pend_valid_reg;
                push_word.match_row   = pend_valid_reg ? pend_row_reg : '0;
                push_word.match_col   = pend_valid_reg ? pend_col_reg : '0;
                push_word.last_result = 1'b1;
                push_word.total_count = cnt_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        mem_en    = rd_issue;
        mem_we    = 1'b0;
        mem_addr  = cell_addr(rd_row_reg, rd_col_reg);
        mem_wdata.flow_valid = s_word.cell_flow_valid;
        mem_wdata.elevation  = s_word.cell_elevation;
        if (s_accept) begin
            mem_addr = cell_addr(s_word.cell_row, s_word.cell_col);
            mem_we   = !is_query;
            mem_en   = is_query ? in_grid : in_store;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pnf_pkg::ST_IDLE;
            rows_reg       <= pnf_pkg::GRID_SIZE_RESET;
            cols_reg       <= pnf_pkg::GRID_SIZE_RESET;
            rd_left_reg    <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    pnf_pkg::REG_GRID_ROWS: rows_reg <= cfg_wdata;
                    pnf_pkg::REG_GRID_COLS: cols_reg <= cfg_wdata;
                    default: rows_reg <= rows_reg;
                endcase
            end
            if (s_accept) begin
                rd_left_reg    <= is_query && in_grid;
                cmp_valid_reg  <= 1'b0;
                pend_valid_reg <= 1'b0;
                cnt_reg        <= '0;
            end else begin
                if (rd_issue && (rd_col_reg == zhi_reg) && (rd_row_reg == whi_reg)) begin
                    rd_left_reg <= 1'b0;
                end
                if (rd_issue) begin
                    cmp_valid_reg <= 1'b1;
                end else if (cmp_adv) begin
                    cmp_valid_reg <= 1'b0;
                end
                if (cmp_adv && cmp_match) begin
                    pend_valid_reg <= 1'b1;
                    cnt_reg        <= cnt_reg + NW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            whi_reg    <= whi_new;
            zlo_reg    <= zlo_new;
            zhi_reg    <= zhi_new;
            rd_row_reg <= wlo_new;
            rd_col_reg <= zlo_new;
        end else if (rd_issue) begin
            if (rd_col_reg == zhi_reg) begin
                rd_col_reg <= zlo_reg;
                rd_row_reg <= rd_row_reg + CW'(1);
            end else begin
                rd_col_reg <= rd_col_reg + CW'(1);
            end
        end
        if (rd_issue) begin
            cmp_row_reg <= rd_row_reg;
            cmp_col_reg <= rd_col_reg;
        end
        if (state_reg == pnf_pkg::ST_CENTRE) begin
            centre_reg <= mem_rdata.elevation;
        end
        if (cmp_adv && cmp_match) begin
            pend_row_reg <= cmp_row_reg;
            pend_col_reg <= cmp_col_reg;
        end
    end

    pnf_grid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid_mem (
        .aclk      (aclk),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    pnf_result_stage u_result_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

// ===== verif/plateau_neighbor_finder_core_tb.sv =====
`timescale 1ns / 100ps

module plateau_neighbor_finder_core_tb;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES = 20;
    localparam int CW = pnf_pkg::COORD_W;
    localparam int SW = pnf_pkg::SIZE_W;
    localparam int EW = pnf_pkg::ELEV_W;
    localparam int NW = pnf_pkg::COUNT_W;

    typedef struct {
        pnf_pkg::in_word_t word;
        bit                hold_for_drain;
    } stim_t;

    typedef enum int {
        PACE_OPEN,
        PACE_COIN,
        PACE_SPARSE,
        PACE_TOGGLE
    } pace_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pnf_pkg::in_word_t s_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pnf_pkg::out_word_t m_word;
    logic cfg_we = 1'b0;
    pnf_pkg::reg_index_t cfg_index = pnf_pkg::REG_GRID_ROWS;
    logic [SW-1:0] cfg_wdata = '0;

    stim_t stim_words[$];
    pnf_pkg::out_word_t match_fifo[$];
    bit all_returned = 1'b1;
    int errors = 0;
    int stim_count = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int ready_run = 0;
    pace_t ready_mode = PACE_OPEN;

    logic [SW-1:0] cfg_rows_q = pnf_pkg::GRID_SIZE_RESET;
    logic [SW-1:0] cfg_cols_q = pnf_pkg::GRID_SIZE_RESET;
    logic signed [EW-1:0] grid_elev [int];
    logic grid_flow [int];
    bit cell_loaded [int];

    plateau_neighbor_finder_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic int cell_idx(int r, int c);
        return r * pnf_pkg::DEF_MAX_COLS + c;
    endfunction

    function automatic int eff_dim(logic [SW-1:0] v, int phys);
        int lim;
        int vi;
        lim = (phys < 256) ? phys : 256;
        vi = int'(v);
        if (vi == 0) return 1;
        if (vi > lim) return lim;
        return vi;
    endfunction

    function automatic void scan_window(pnf_pkg::in_word_t w);
        int rows;
        int cols;
        int r;
        int c;
        int y;
        int x;
        int n;
        logic signed [EW-1:0] centre;
        pnf_pkg::out_word_t hits[$];
        pnf_pkg::out_word_t o;
        rows = eff_dim(cfg_rows_q, pnf_pkg::DEF_MAX_ROWS);
        cols = eff_dim(cfg_cols_q, pnf_pkg::DEF_MAX_COLS);
        r = int'(w.cell_row);
        c = int'(w.cell_col);
        o = '0;
        if (r < rows && c < cols) begin
            centre = grid_elev[cell_idx(r, c)];
            for (y = (r > 0) ? r - 1 : 0; y <= ((r + 1 < rows) ? r + 1 : rows - 1); y++) begin
                for (x = (c > 0) ? c - 1 : 0; x <= ((c + 1 < cols) ? c + 1 : cols - 1); x++) begin
                    if (grid_flow[cell_idx(y, x)] && grid_elev[cell_idx(y, x)] == centre) begin
                        o = '0;
                        o.found = 1'b1;
                        o.match_row = CW'(y);
                        o.match_col = CW'(x);
                        hits.push_back(o);
                    end
                end
            end
        end
        n = hits.size();
        if (n == 0) begin
            o = '0;
            o.last_result = 1'b1;
            match_fifo.push_back(o);
        end else begin
            hits[n-1].last_result = 1'b1;
            hits[n-1].total_count = NW'(n);
            for (y = 0; y < n; y++) begin
                match_fifo.push_back(hits[y]);
            end
        end
    endfunction

    function automatic logic [EW-1:0] pick_elev();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return EW'($urandom_range(0, 3) << 16);
            default: return EW'($urandom);
        endcase
    endfunction

    function automatic int pick_coord(int n);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return n - 1;
            2: return (n < 256) ? int'($urandom_range(n, 255)) : 255;
            default: return int'($urandom_range(0, n - 1));
        endcase
    endfunction

    task automatic push_word(logic op, int r, int c, logic [EW-1:0] e, logic f, bit drain);
        stim_t s;
        s.word.operation = op;
        s.word.cell_row = CW'(r);
        s.word.cell_col = CW'(c);
        s.word.cell_elevation = e;
        s.word.cell_flow_valid = f;
        s.hold_for_drain = drain;
        stim_words.push_back(s);
        stim_count++;
    endtask

    task automatic push_write(int r, int c, logic [EW-1:0] e, logic f);
        cell_loaded[cell_idx(r, c)] = 1'b1;
        push_word(pnf_pkg::OP_WRITE, r, c, e, f, 1'b0);
    endtask

    // Every cell the scan will read is loaded first, since the grid memory
    // holds no defined value until written.
    task automatic push_query(int r, int c, bit drain);
        int rows;
        int cols;
        int y;
        int x;
        rows = eff_dim(cfg_rows_q, pnf_pkg::DEF_MAX_ROWS);
        cols = eff_dim(cfg_cols_q, pnf_pkg::DEF_MAX_COLS);
        if (r < rows && c < cols) begin
            for (y = (r > 0) ? r - 1 : 0; y <= ((r + 1 < rows) ? r + 1 : rows - 1); y++) begin
                for (x = (c > 0) ? c - 1 : 0; x <= ((c + 1 < cols) ? c + 1 : cols - 1); x++) begin
                    if (!cell_loaded.exists(cell_idx(y, x))) begin
                        push_write(y, x, pick_elev(), ($urandom_range(0, 1) != 0));
                    end
                end
            end
        end
        push_word(pnf_pkg::OP_QUERY, r, c, EW'($urandom), ($urandom_range(0, 1) != 0), drain);
    endtask

    task automatic random_phase(int budget);
        int first;
        int rows;
        int cols;
        int r;
        int c;
        int dy;
        int dx;
        bit mid;
        logic [EW-1:0] base;
        first = stim_count;
        rows = eff_dim(cfg_rows_q, pnf_pkg::DEF_MAX_ROWS);
        cols = eff_dim(cfg_cols_q, pnf_pkg::DEF_MAX_COLS);
        while (stim_count - first < budget) begin
            r = pick_coord(rows);
            c = pick_coord(cols);
            if ($urandom_range(0, 9) < 7) begin
                base = pick_elev();
                for (dy = -1; dy <= 1; dy++) begin
                    for (dx = -1; dx <= 1; dx++) begin
                        mid = (dy == 0 && dx == 0);
                        if (r + dy >= 0 && r + dy < 256 && c + dx >= 0 && c + dx < 256 &&
                            (mid || $urandom_range(0, 3) != 0)) begin
                            push_write(r + dy, c + dx,
                                       (mid || $urandom_range(0, 2) != 0) ? base : pick_elev(),
                                       ($urandom_range(0, 1) != 0));
                        end
                    end
                end
                push_query(r, c, $urandom_range(0, 24) == 0);
            end else if ($urandom_range(0, 1) != 0) begin
                push_write(int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                           EW'($urandom), ($urandom_range(0, 1) != 0));
            end else begin
                push_query(int'($urandom_range(0, 255)), int'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (stim_words.size() != 0 || s_valid || !all_returned);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(pnf_pkg::reg_index_t idx, logic [SW-1:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == pnf_pkg::REG_GRID_ROWS) begin
            cfg_rows_q = v;
        end else begin
            cfg_cols_q = v;
        end
        @(negedge aclk);
    endtask

    task automatic set_grid(logic [SW-1:0] rows, logic [SW-1:0] cols);
        wait_idle();
        write_reg(pnf_pkg::REG_GRID_ROWS, rows);
        write_reg(pnf_pkg::REG_GRID_COLS, cols);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : driver
        stim_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= $urandom_range(1, 10);
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (stim_words.size() != 0 &&
                         !(stim_words[0].hold_for_drain && (s_valid || !all_returned))) begin
                nxt = stim_words.pop_front();
                s_word <= nxt.word;
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(1, 10);
                    gap_left <= ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : sink_pace
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_run <= 0;
            ready_mode <= PACE_OPEN;
        end else if (ready_run == 0) begin
            ready_mode <= pace_t'($urandom_range(0, 3));
            ready_run <= $urandom_range(3, 30);
            m_ready <= 1'b1;
        end else begin
            ready_run <= ready_run - 1;
            case (ready_mode)
                PACE_OPEN: m_ready <= 1'b1;
                PACE_COIN: m_ready <= ($urandom_range(0, 1) != 0);
                PACE_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
                default: m_ready <= ~m_ready;
            endcase
        end
    end

    always @(posedge aclk) begin : monitor
        pnf_pkg::out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (match_fifo.size() == 0) begin
                    $error("result word with no expectation waiting");
                    errors++;
                end else begin
                    want = match_fifo.pop_front();
                    check_field("found", int'(want.found), int'(m_word.found));
                    check_field("match_row", int'(want.match_row), int'(m_word.match_row));
                    check_field("match_col", int'(want.match_col), int'(m_word.match_col));
                    check_field("last_result", int'(want.last_result),
                                int'(m_word.last_result));
                    check_field("total_count", int'(want.total_count),
                                int'(m_word.total_count));
                end
            end
            if (s_valid && s_ready) begin
                if (s_word.operation == pnf_pkg::OP_WRITE) begin
                    grid_elev[cell_idx(int'(s_word.cell_row), int'(s_word.cell_col))] =
                        s_word.cell_elevation;
                    grid_flow[cell_idx(int'(s_word.cell_row), int'(s_word.cell_col))] =
                        s_word.cell_flow_valid;
                end else begin
                    scan_window(s_word);
                end
            end
        end
        all_returned <= (match_fifo.size() == 0);
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int dy;
        int dx;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Corner window at the most negative and most positive elevations.
        push_write(0, 0, 32'h8000_0000, 1'b1);
        push_write(0, 1, 32'h8000_0000, 1'b1);
        push_write(1, 0, 32'h8000_0000, 1'b0);
        push_write(1, 1, 32'h7FFF_FFFF, 1'b1);
        push_query(0, 0, 1'b0);
        push_write(254, 254, 32'h7FFF_FFFF, 1'b1);
        push_write(254, 255, 32'h7FFF_FFFF, 1'b1);
        push_write(255, 254, 32'h7FFF_FFFF, 1'b1);
        push_write(255, 255, 32'h7FFF_FFFF, 1'b0);
        push_query(255, 255, 1'b1);
        // A flat window where all nine cells match, then one with no match.
        for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
                push_write(100 + dy, 100 + dx, 32'h0001_0000, 1'b1);
            end
        end
        push_query(100, 100, 1'b0);
        push_write(100, 100, 32'hFFFF_FFFF, 1'b0);
        push_query(100, 100, 1'b0);
        random_phase(30);

        // Centres outside a small grid, and its far corner.
        set_grid(9'd3, 9'd5);
        push_query(3, 0, 1'b1);
        push_query(0, 5, 1'b0);
        push_query(2, 4, 1'b0);
        random_phase(40);

        set_grid(9'd0, 9'd511);
        random_phase(25);
        set_grid(9'd1, 9'd1);
        random_phase(15);
        set_grid(9'd257, 9'd2);
        random_phase(30);
        set_grid(SW'($urandom_range(1, 300)), SW'($urandom_range(1, 300)));
        random_phase(50);
        set_grid(9'd256, 9'd256);
        random_phase(60);

        wait_idle();
        if (match_fifo.size() != 0) begin
            $error("%0d result words never arrived", match_fifo.size());
            errors++;
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
